[rtl/core/itis_pkg.sv]
// Shared widths, constants, codes and control types of the table inverse search.
package itis_pkg;

  // Field widths.
  localparam int FRAC_BITS = 20;
  localparam int MASS_W    = 25;
  localparam int DENS_W    = 32;
  localparam int IDX_W     = 11;
  localparam int TRIAL_W   = 34;
  localparam int DIFF_W    = 33;
  localparam int PROD_W    = 54;
  localparam int IDXS_W    = 12;

  // Mass constants, unsigned Q.20.
  localparam logic [MASS_W-1:0] MASS_ONE   = MASS_W'(1 << FRAC_BITS);
  localparam logic [MASS_W-1:0] MASS_INIT  = MASS_W'(27 << (FRAC_BITS - 1));
  localparam logic [MASS_W-1:0] MASS_HIGH  = MASS_W'(17 << FRAC_BITS);
  localparam logic [MASS_W-1:0] MASS_LOW   = MASS_W'(8 << FRAC_BITS);
  localparam logic [MASS_W-1:0] STEP_FIRST = MASS_W'(1 << (FRAC_BITS - 1));
  localparam logic [MASS_W-1:0] STEP_LAST  = MASS_W'(2);

  // Density returned above the top of the table, signed Q17.16.
  localparam logic signed [TRIAL_W-1:0] FLOOR_DENSITY = -TRIAL_W'(65536000);

  // Item commands.
  typedef enum logic {
    CMD_LOAD  = 1'b0,
    CMD_QUERY = 1'b1
  } cmd_t;

  // Stage strobes from the sequencer to the lookup datapath.
  typedef struct packed {
    logic rd;
    logic diff;
    logic mul;
  } lookup_ctl_t;

endpackage

[rtl/core/itis_in_if.sv]
// Input channel of the table inverse search: valid, ready and the item fields.
interface itis_in_if;
  logic                               valid;
  logic                               ready;
  logic                               cmd;
  logic [itis_pkg::IDX_W-1:0]         entry_index;
  logic signed [itis_pkg::DENS_W-1:0] entry_value;
  logic signed [itis_pkg::DENS_W-1:0] target_density;

  modport source (
    output valid, cmd, entry_index, entry_value, target_density,
    input  ready
  );
  modport sink (
    input  valid, cmd, entry_index, entry_value, target_density,
    output ready
  );
endinterface

[rtl/core/itis_out_if.sv]
// Result channel of the table inverse search: valid, ready and the found mass.
interface itis_out_if;
  logic                       valid;
  logic                       ready;
  logic [itis_pkg::MASS_W-1:0] found_mass;

  modport source (
    output valid, found_mass,
    input  ready
  );
  modport sink (
    input  valid, found_mass,
    output ready
  );
endinterface

[rtl/core/itis_table_mem.sv]
// Density table storage: one write port and two registered read ports.
module itis_table_mem #(
  parameter int DEPTH = 1802,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic                                clk,
  input  logic                                wr_en,
  input  logic [AW-1:0]                       wr_addr,
  input  logic signed [itis_pkg::DENS_W-1:0]  wr_data,
  input  logic                                rd_en,
  input  logic [AW-1:0]                       rd_addr_a,
  input  logic [AW-1:0]                       rd_addr_b,
  output logic signed [itis_pkg::DENS_W-1:0]  rd_data_a,
  output logic signed [itis_pkg::DENS_W-1:0]  rd_data_b
);
  import itis_pkg::*;

  logic signed [DENS_W-1:0] mem [DEPTH];
  logic signed [DENS_W-1:0] rd_a_r;
  logic signed [DENS_W-1:0] rd_b_r;

  // Write and read in the same clocked block; read data is registered and appears in the next cycle.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_a_r <= mem[rd_addr_a];
      rd_b_r <= mem[rd_addr_b];
    end
  end

  assign rd_data_a = rd_a_r;
  assign rd_data_b = rd_b_r;

endmodule

[rtl/core/itis_interp.sv]
// Table lookup datapath: address generation, difference, product and interpolated sum.
module itis_interp #(
  parameter int DEPTH = 1802,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic                                 clk,
  input  itis_pkg::lookup_ctl_t                ctl,
  input  logic [itis_pkg::MASS_W-1:0]          mass,
  output logic [AW-1:0]                        rd_addr_a,
  output logic [AW-1:0]                        rd_addr_b,
  input  logic signed [itis_pkg::DENS_W-1:0]   rd_data_a,
  input  logic signed [itis_pkg::DENS_W-1:0]   rd_data_b,
  output logic signed [itis_pkg::TRIAL_W-1:0]  trial
);
  import itis_pkg::*;

  localparam logic [IDXS_W-1:0] LAST_IDX = IDXS_W'(DEPTH - 1);

  logic                     over;
  logic                     under;
  logic [MASS_W-1:0]        span;
  logic [31:0]              span_w;
  logic [31:0]              pos;
  logic [IDXS_W-1:0]        idx_lo;
  logic [IDXS_W-1:0]        idx_hi;
  logic [IDXS_W-1:0]        sat_lo;
  logic [IDXS_W-1:0]        sat_hi;

  logic                     over_r;
  logic [FRAC_BITS-1:0]     frac_r;
  logic signed [DENS_W-1:0] lo_r;
  logic signed [DIFF_W-1:0] diff_r;
  logic signed [PROD_W-1:0] prod_r;

  // Table position (17 - m) * 200 in Q.20; the multiply by 200 is three shifted adds.
  always_comb begin
    over   = mass > MASS_HIGH;
    under  = mass <= MASS_LOW;
    span   = MASS_HIGH - mass;
    span_w = 32'(span);
    pos    = (span_w << 7) + (span_w << 6) + (span_w << 3);
    idx_lo = {1'b0, pos[FRAC_BITS +: IDX_W]};
    idx_hi = idx_lo + IDXS_W'(1);
    // At or below the low end of mass both reads go to the last entry.
    if (under || idx_lo > LAST_IDX) begin
      sat_lo = LAST_IDX;
    end else begin
      sat_lo = idx_lo;
    end
    if (under || idx_hi > LAST_IDX) begin
      sat_hi = LAST_IDX;
    end else begin
      sat_hi = idx_hi;
    end
  end

  assign rd_addr_a = AW'(sat_lo);
  assign rd_addr_b = AW'(sat_hi);

  // Stage registers, one stage per sequencer strobe.
  always_ff @(posedge clk) begin
    if (ctl.rd) begin
      over_r <= over;
      frac_r <= under ? '0 : pos[FRAC_BITS-1:0];
    end
    if (ctl.diff) begin
      lo_r   <= rd_data_a;
      diff_r <= DIFF_W'(rd_data_b) - DIFF_W'(rd_data_a);
    end
    if (ctl.mul) begin
      prod_r <= PROD_W'($signed({1'b0, frac_r})) * PROD_W'(diff_r);
    end
  end

  // Interpolated value; the arithmetic shift floors the scaled product.
  assign trial = over_r ? FLOOR_DENSITY
                        : TRIAL_W'(lo_r) + TRIAL_W'(prod_r >>> FRAC_BITS);

endmodule

[rtl/core/itis_search_ctrl.sv]
// Search sequencer: whole steps, then bisection, and the result register.
module itis_search_ctrl (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 query_start,
  input  logic signed [itis_pkg::DENS_W-1:0]   target,
  input  logic signed [itis_pkg::TRIAL_W-1:0]  trial,
  output itis_pkg::lookup_ctl_t                ctl,
  output logic [itis_pkg::MASS_W-1:0]          mass,
  output logic                                 busy,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [itis_pkg::MASS_W-1:0]          found_mass
);
  import itis_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_DIFF,
    S_MUL,
    S_SUM,
    S_DONE
  } state_t;

  typedef enum logic [1:0] {
    PH_DOWN,
    PH_UP,
    PH_BISECT
  } phase_t;

  state_t                   state_r, state_nxt;
  phase_t                   phase_r, phase_nxt;
  logic [MASS_W-1:0]        m_r, m_nxt;
  logic [MASS_W-1:0]        step_r, step_nxt;
  logic signed [DENS_W-1:0] target_r, target_nxt;
  logic                     out_valid_r, out_valid_nxt;
  logic [MASS_W-1:0]        found_r, found_nxt;

  logic                     lt;
  logic                     gt;
  logic                     down_go;
  logic                     up_go;

  // Outcome of the lookup just finished.
  always_comb begin
    lt      = trial < TRIAL_W'(target_r);
    gt      = trial > TRIAL_W'(target_r);
    down_go = (phase_r == PH_DOWN) && lt && (m_r > MASS_LOW);
    up_go   = (phase_r != PH_BISECT) && gt && (m_r < MASS_HIGH);
  end

  // Next state of the search.
  always_comb begin
    state_nxt     = state_r;
    phase_nxt     = phase_r;
    m_nxt         = m_r;
    step_nxt      = step_r;
    target_nxt    = target_r;
    found_nxt     = found_r;
    out_valid_nxt = out_valid_r && !out_ready;
    unique case (state_r)
      S_IDLE: begin
        if (query_start) begin
          state_nxt  = S_READ;
          phase_nxt  = PH_DOWN;
          m_nxt      = MASS_INIT;
          step_nxt   = STEP_FIRST;
          target_nxt = target;
        end
      end
      S_READ: begin
        state_nxt = S_DIFF;
      end
      S_DIFF: begin
        state_nxt = S_MUL;
      end
      S_MUL: begin
        state_nxt = S_SUM;
      end
      S_SUM: begin
        if (down_go) begin
          m_nxt     = m_r - MASS_ONE;
          state_nxt = S_READ;
        end else if (up_go) begin
          m_nxt     = m_r + MASS_ONE;
          phase_nxt = PH_UP;
          state_nxt = S_READ;
        end else begin
          // Bisection step; the value after the finest step is not looked up.
          m_nxt     = lt ? m_r - step_r : m_r + step_r;
          phase_nxt = PH_BISECT;
          step_nxt  = step_r >> 1;
          state_nxt = (step_r == STEP_LAST) ? S_DONE : S_READ;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          found_nxt     = m_r;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State and registered outputs.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      phase_r     <= PH_DOWN;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      out_valid_r <= out_valid_nxt;
      m_r         <= m_nxt;
      step_r      <= step_nxt;
      target_r    <= target_nxt;
      found_r     <= found_nxt;
    end
  end

  assign ctl.rd     = state_r == S_READ;
  assign ctl.diff   = state_r == S_DIFF;
  assign ctl.mul    = state_r == S_MUL;
  assign mass       = m_r;
  assign busy       = state_r != S_IDLE;
  assign out_valid  = out_valid_r;
  assign found_mass = found_r;

endmodule

[rtl/core/interpolated_table_inverse_search.sv]
// Inverse search of a linearly interpolated density table.
//
// Input channel in_ch carries load and query items. A load item (cmd 0) writes
// entry_value into table entry entry_index in the cycle it is accepted and
// gives no result; an index at or beyond TABLE_ENTRIES is dropped. A query item
// (cmd 1) searches for the mass whose interpolated table value matches
// target_density and gives one item on out_ch with found_mass.
// Queries run one at a time. Each table lookup reads both neighbouring entries,
// then takes the difference, the multiply, and the sum and compare. A query makes
// 19 + w lookups, w being the number of whole steps (at most 16); its result
// becomes valid in the same cycle as the input is ready again.
// The result sits in an output register; a stalled receiver holds it there and
// the next item is still accepted, but a following query waits at its end
// until the register is free. Reset clears the control state and drops any
// pending result; the table holds no reset value and must be written before
// the entries a query needs are read.
module interpolated_table_inverse_search #(
  parameter int TABLE_ENTRIES = 1802
) (
  input  logic       clk,
  input  logic       rst_n,
  itis_in_if.sink    in_ch,
  itis_out_if.source out_ch
);
  import itis_pkg::*;

  localparam int AW = $clog2(TABLE_ENTRIES);
  localparam logic [IDXS_W-1:0] LAST_IDX = IDXS_W'(TABLE_ENTRIES - 1);

  logic                      in_acc;
  logic                      busy;
  logic                      wr_en;
  logic                      query_start;
  lookup_ctl_t               ctl;
  logic [MASS_W-1:0]         mass;
  logic [AW-1:0]             rd_addr_a;
  logic [AW-1:0]             rd_addr_b;
  logic signed [DENS_W-1:0]  rd_data_a;
  logic signed [DENS_W-1:0]  rd_data_b;
  logic signed [TRIAL_W-1:0] trial;

  // Item acceptance and command decode.
  assign in_ch.ready = !busy;
  assign in_acc      = in_ch.valid && !busy;
  assign wr_en       = in_acc && (in_ch.cmd == CMD_LOAD)
                       && ({1'b0, in_ch.entry_index} <= LAST_IDX);
  assign query_start = in_acc && (in_ch.cmd == CMD_QUERY);

  // Table storage. Loads and query reads never overlap: a query starts only when idle.
  itis_table_mem #(
    .DEPTH (TABLE_ENTRIES)
  ) u_mem (
    .clk       (clk),
    .wr_en     (wr_en),
    .wr_addr   (AW'(in_ch.entry_index)),
    .wr_data   (in_ch.entry_value),
    .rd_en     (ctl.rd),
    .rd_addr_a (rd_addr_a),
    .rd_addr_b (rd_addr_b),
    .rd_data_a (rd_data_a),
    .rd_data_b (rd_data_b)
  );

  // Lookup datapath.
  itis_interp #(
    .DEPTH (TABLE_ENTRIES)
  ) u_interp (
    .clk       (clk),
    .ctl       (ctl),
    .mass      (mass),
    .rd_addr_a (rd_addr_a),
    .rd_addr_b (rd_addr_b),
    .rd_data_a (rd_data_a),
    .rd_data_b (rd_data_b),
    .trial     (trial)
  );

  // Search sequencer and result register.
  itis_search_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .query_start (query_start),
    .target      (in_ch.target_density),
    .trial       (trial),
    .ctl         (ctl),
    .mass        (mass),
    .busy        (busy),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .found_mass  (out_ch.found_mass)
  );

endmodule

[rtl/core/itis_checker.sv]
// Port-level assertions of the table inverse search, bound to the top level.
module itis_port_props (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        in_cmd,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [itis_pkg::MASS_W-1:0] found_mass
);
  import itis_pkg::*;

  // A query keeps the block busy in the cycle after it is accepted.
  a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && (in_cmd == CMD_QUERY)) |=> !in_ready)
    else $error("input still ready after a query item was accepted");

  // A load item never raises a result.
  a_load_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && (in_cmd == CMD_LOAD)) |=> !$rose(out_valid))
    else $error("result appeared after a load item");

  // A result appears only at the end of a search, while the input was held off.
  a_result_from_search: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> !$past(in_ready))
    else $error("result appeared without a search in progress");

  // A stalled result holds its value.
  a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(found_mass)))
    else $error("stalled result changed or was dropped");

endmodule

bind interpolated_table_inverse_search itis_port_props u_itis_port_props (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_ch.valid),
  .in_ready   (in_ch.ready),
  .in_cmd     (in_ch.cmd),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .found_mass (out_ch.found_mass)
);

[verif/itis_checker.sv]
// Checker that predicts found masses from observed items and compares the results.
`timescale 1ns / 100ps

module itis_checker #(
  parameter int TABLE_ENTRIES = 1802
) (
  input  logic clk,
  input  logic rst_n,
  itis_in_if   in_mon,
  itis_out_if  out_mon,
  output int   fail_count,
  output int   pending
);
  import itis_pkg::*;

  localparam longint ONE_L   = longint'(MASS_ONE);
  localparam longint START_L = longint'(MASS_INIT);
  localparam longint HIGH_L  = longint'(MASS_HIGH);
  localparam longint LOW_L   = longint'(MASS_LOW);
  localparam longint FLOOR_L = longint'(FLOOR_DENSITY);
  localparam int     BISECT_STEPS = 19;
  localparam longint ROWS_PER_MASS = 200;

  // Private copy of the density table, updated by every accepted load item with an index inside the table.
  logic signed [DENS_W-1:0] density_copy [TABLE_ENTRIES];

  // Masses still owed by the block, oldest first.
  logic [MASS_W-1:0] mass_expected [$];
  logic [MASS_W-1:0] mass_want;
  int                fails = 0;

  assign fail_count = fails;

  // Table entry with the index saturated to the last row.
  function automatic longint entry_at(longint idx);
    if (idx >= TABLE_ENTRIES) idx = TABLE_ENTRIES - 1;
    return longint'(density_copy[idx]);
  endfunction

  // Interpolated density at a Q.20 mass, exact at 64 bits.
  function automatic longint density_at(longint m);
    longint d, idx, frac, lo, hi;
    if (m > HIGH_L) return FLOOR_L;
    if (m <= LOW_L) return entry_at(TABLE_ENTRIES - 1);
    d    = (HIGH_L - m) * ROWS_PER_MASS;
    idx  = d >>> FRAC_BITS;
    frac = d & (ONE_L - 1);
    lo   = entry_at(idx);
    hi   = entry_at(idx + 1);
    return lo + ((frac * (hi - lo)) >>> FRAC_BITS);
  endfunction

  // Whole steps until the target is bracketed, then bisection down to 2^-19.
  function automatic logic [MASS_W-1:0] search_mass(longint target);
    longint m, trial;
    int     k;
    m     = START_L;
    trial = density_at(m);
    while (trial < target && m > LOW_L) begin
      m     = m - ONE_L;
      trial = density_at(m);
    end
    while (trial > target && m < HIGH_L) begin
      m     = m + ONE_L;
      trial = density_at(m);
    end
    for (k = 1; k <= BISECT_STEPS; k++) begin
      if (trial < target) m = m - (ONE_L >>> k);
      else m = m + (ONE_L >>> k);
      trial = density_at(m);
    end
    return MASS_W'(m);
  endfunction

  // Results are checked before new items are taken in, all on the clock edge.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_mon.valid && out_mon.ready) begin
        if (mass_expected.size() == 0) begin
          if (fails < 10)
            $display("%0t: result item with nothing expected, found_mass %h",
                     $realtime, out_mon.found_mass);
          fails++;
        end else begin
          mass_want = mass_expected.pop_front();
          if (out_mon.found_mass !== mass_want) begin
            if (fails < 10)
              $display("%0t: found_mass expected %h actual %h",
                       $realtime, mass_want, out_mon.found_mass);
            fails++;
          end
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        if (in_mon.cmd == CMD_QUERY)
          mass_expected.push_back(search_mass(longint'(in_mon.target_density)));
        else if (in_mon.entry_index < TABLE_ENTRIES)
          density_copy[in_mon.entry_index] = in_mon.entry_value;
      end
    end
    pending <= mass_expected.size();
  end

endmodule

[verif/tb_interpolated_table_inverse_search.sv]
// Stimulus, flow control and verdict for the interpolated table inverse search.
`timescale 1ns / 100ps

module tb_interpolated_table_inverse_search;
  import itis_pkg::*;

  localparam int TABLE_ENTRIES = 1802;
  localparam int RANDOM_ITEMS  = 240;
  localparam int HOLD_CYCLES   = 2500;
  localparam int DRAIN_CYCLES  = 200;
  // Queries only touch entries of this region. A target kept strictly between
  // the entries at mass 14.5 and 12.5 holds the whole steps between those
  // masses, and bisection never leaves the unit step where they stop.
  localparam int REGION_FIRST  = 500;
  localparam int REGION_LAST   = 901;
  localparam int BRACKET_LO    = 500;
  localparam int BRACKET_HI    = 900;
  localparam int MID_ENTRY     = 700;
  localparam logic signed [DENS_W-1:0] DENS_MAX   = 32'sh7FFF_FFFF;
  localparam logic signed [DENS_W-1:0] DENS_MIN   = 32'sh8000_0000;
  localparam logic signed [DENS_W-1:0] DENS_FLOOR = DENS_W'(FLOOR_DENSITY);

  logic clk;
  logic rst_n;
  logic quiet;
  logic hold_go;
  logic hold_off;
  int   fail_count;
  int   pending;

  // What the table holds, used only to aim queries at interesting targets.
  logic signed [DENS_W-1:0] table_image [TABLE_ENTRIES];

  itis_in_if  in_ch ();
  itis_out_if out_ch ();

  interpolated_table_inverse_search #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) uut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  itis_checker #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_mon    (in_ch),
    .out_mon   (out_ch),
    .fail_count(fail_count),
    .pending   (pending)
  );

  // Clock with a 4 ns period.
  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // Offer one item, with random idle cycles ahead of it, until it is accepted.
  task automatic send_item(input cmd_t c, input logic [IDX_W-1:0] idx,
                           input logic signed [DENS_W-1:0] val,
                           input logic signed [DENS_W-1:0] tgt);
    while (!quiet && $urandom_range(99) < 28) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid          <= 1'b1;
    in_ch.cmd            <= c;
    in_ch.entry_index    <= idx;
    in_ch.entry_value    <= val;
    in_ch.target_density <= tgt;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  // A load item; the unused target is random noise.
  task automatic load_entry(input logic [IDX_W-1:0] idx,
                            input logic signed [DENS_W-1:0] val);
    if (idx < TABLE_ENTRIES) table_image[idx] = val;
    send_item(CMD_LOAD, idx, val, $urandom);
  endtask

  // A query item, its target pulled strictly inside the bracketing entries;
  // the unused entry fields are random noise.
  task automatic ask_mass(input logic signed [DENS_W-1:0] tgt);
    longint lo_l;
    longint hi_l;
    longint t_l;
    lo_l = longint'(table_image[BRACKET_LO]) + 1;
    hi_l = longint'(table_image[BRACKET_HI]) - 1;
    t_l  = longint'(tgt);
    if (t_l < lo_l) t_l = lo_l;
    if (t_l > hi_l) t_l = hi_l;
    send_item(CMD_QUERY, IDX_W'($urandom_range(2047)), $urandom, DENS_W'(t_l));
  endtask

  // Write the searched region with a gentle rising curve and a little noise.
  task automatic fill_table();
    longint v;
    for (int i = REGION_FIRST; i <= REGION_LAST; i++) begin
      v = -900 * 65536 + longint'(i) * 33000 + $urandom_range(2000);
      load_entry(IDX_W'(i), DENS_W'(v));
    end
  endtask

  // Directed items: field extremes, exact entries, dropped loads and extreme entries.
  task automatic run_directed();
    ask_mass(DENS_MAX);
    ask_mass(DENS_MIN);
    ask_mass(DENS_FLOOR);
    ask_mass(table_image[MID_ENTRY]);
    ask_mass(table_image[MID_ENTRY] + 1);
    ask_mass(table_image[MID_ENTRY] - 1);
    ask_mass(table_image[600]);
    ask_mass(table_image[800] + 1);
    ask_mass('0);
    load_entry(IDX_W'(TABLE_ENTRIES), '0);
    load_entry(11'h7FF, DENS_MAX);
    ask_mass(table_image[MID_ENTRY]);
    load_entry(IDX_W'(BRACKET_LO), DENS_MIN);
    load_entry(IDX_W'(BRACKET_HI), DENS_MAX);
    ask_mass(DENS_MIN);
    ask_mass(DENS_MAX);
    ask_mass('0);
    load_entry(IDX_W'(BRACKET_HI - 1), DENS_MIN);
    load_entry(IDX_W'(MID_ENTRY + 1), DENS_MAX);
    ask_mass(DENS_MAX - 1);
    ask_mass(DENS_MIN + 1);
    ask_mass(table_image[MID_ENTRY]);
  endtask

  // Mostly queries aimed near table values, with loads that keep or break the shape.
  task automatic run_random(input int phase);
    int                       pick;
    int                       k;
    logic [IDX_W-1:0]         idx;
    logic signed [DENS_W-1:0] val;
    logic signed [DENS_W-1:0] tgt;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (phase == 1 && n == 60) quiet <= 1'b1;
      if (phase == 1 && n == 180) quiet <= 1'b0;
      pick = $urandom_range(99);
      if (pick < 30) begin
        if ($urandom_range(1) == 0)
          idx = IDX_W'(REGION_FIRST + $urandom_range(REGION_LAST - REGION_FIRST));
        else
          idx = IDX_W'($urandom_range(2047));
        if (idx >= REGION_FIRST && idx <= REGION_LAST && $urandom_range(3) != 0)
          val = table_image[idx] + DENS_W'($urandom_range(4000)) - 2000;
        else
          val = $urandom;
        // The bracketing entries keep their order, so queries stay in the region.
        if (idx == BRACKET_LO && val >= table_image[BRACKET_HI] - 1)
          val = table_image[BRACKET_HI] - 2;
        if (idx == BRACKET_HI && val <= table_image[BRACKET_LO] + 1)
          val = table_image[BRACKET_LO] + 2;
        load_entry(idx, val);
      end else begin
        pick = $urandom_range(99);
        k    = REGION_FIRST + $urandom_range(REGION_LAST - REGION_FIRST);
        if (pick < 70)
          tgt = table_image[k] + DENS_W'($urandom_range(131072)) - 65536;
        else if (pick < 85)
          tgt = table_image[k];
        else if (pick < 95)
          tgt = $urandom;
        else begin
          case ($urandom_range(2))
            0: tgt = DENS_MAX;
            1: tgt = DENS_MIN;
            default: tgt = DENS_FLOOR;
          endcase
        end
        ask_mass(tgt);
      end
    end
  endtask

  // Receiver: random stalls, none in the quiet stretch, and the long hold-off.
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off) out_ch.ready <= 1'b0;
      else if (quiet) out_ch.ready <= 1'b1;
      else out_ch.ready <= ($urandom_range(99) >= 28);
    end
  end

  // Long hold-off of the receiver, so that the block fills and stalls its input.
  initial begin
    hold_off <= 1'b0;
    wait (hold_go);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_off <= 1'b0;
  end

  // Main sequence: reset, table fill, directed items, then two random runs.
  initial begin
    rst_n                <= 1'b0;
    quiet                <= 1'b0;
    hold_go              <= 1'b0;
    in_ch.valid          <= 1'b0;
    in_ch.cmd            <= CMD_LOAD;
    in_ch.entry_index    <= '0;
    in_ch.entry_value    <= '0;
    in_ch.target_density <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    fill_table();
    run_directed();
    hold_go <= 1'b1;
    for (int phase = 0; phase < 2; phase++) begin
      run_random(phase);
    end
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending == 0)
      $display("interpolated_table_inverse_search: match");
    else
      $display("interpolated_table_inverse_search: mismatch");
    $finish;
  end

  // Watchdog well beyond the slowest correct run.
  initial begin
    #20000000;
    $display("interpolated_table_inverse_search: mismatch");
    $finish;
  end

endmodule
